// ----- design/assert_macros.svh -----
// Assertion helpers used by krct_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/krct_pkg.sv -----
// ----------------------------------------------------------------------------
// krct_pkg
// Shared types and constants for the keyed ratio calibration table.
// ----------------------------------------------------------------------------
`default_nettype none

package krct_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int KEY_BITS_DEF      = 64;
    localparam int FRAC_BITS_DEF     = 16;

    localparam int RATIO_W = 24;
    localparam int COUNT_W = 32;
    localparam int WIN_W   = 8;
    localparam int STAT_W  = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd2;

    localparam logic [STAT_W-1:0] ST_UPDATED = 3'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FOUND   = 3'd3;
    localparam logic [STAT_W-1:0] ST_DEFAULT = 3'd4;

    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_QUERY   = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic div_start;  // launch divider
        logic scan_clr;   // reset scan index
        logic scan_step;  // latch compare; advance index on a miss
        logic rd_issue;   // read entry at scan index
        logic blend_pre;  // form weight and difference
        logic blend_start;
        logic commit;     // write entry; bump fill on a new key
        logic set_result; // form result
    } krct_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic smp_done;   // sample division finished for this item
        logic is_query;
        logic ignore;     // zero operand or out of band
        logic scan_end;   // index reached fill count
        logic hit;        // registered compare of issued read
        logic full;
    } krct_stat_t;

endpackage

`default_nettype wire

// ----- design/krct_ram.sv -----
// ----------------------------------------------------------------------------
// krct_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module krct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/krct_div.sv -----
// ----------------------------------------------------------------------------
// krct_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module krct_div
    import krct_pkg::*;
#(
    parameter int N_W = 56,
    parameter int D_W = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [N_W-1:0] num,
    input  wire logic [D_W-1:0] den,
    output logic                done,
    output logic      [N_W-1:0] quo
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W:0]     rem_reg, rem_next;
    logic [D_W-1:0]   den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [D_W:0]     trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[D_W-1:0], quo_reg[N_W-1]};
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = CNT_W'(N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ----- design/krct_datapath.sv -----
// ----------------------------------------------------------------------------
// krct_datapath
// Item registers, divider, table memories, scan and blend arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module krct_datapath
    import krct_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = KEY_BITS_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire krct_cmd_t          ctl,
    output krct_stat_t              stat,
    input  wire logic               cmd,
    input  wire logic [63:0]        key,
    input  wire logic [31:0]        real_count,
    input  wire logic [31:0]        est_count,
    input  wire logic [RATIO_W-1:0] ratio_floor,
    input  wire logic [RATIO_W-1:0] ratio_ceiling,
    input  wire logic [WIN_W-1:0]   window_len,
    output logic      [RATIO_W-1:0] ratio_out,
    output logic      [COUNT_W-1:0] sample_total,
    output logic      [STAT_W-1:0]  status
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
    localparam int QN_W   = 32 + FRAC_BITS;
    localparam logic [RATIO_W-1:0] ONE_RATIO =
        (FRAC_BITS >= RATIO_W) ? {RATIO_W{1'b1}} : RATIO_W'(1 << FRAC_BITS);

    logic                 cmd_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [31:0]          real_reg, est_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    idx_reg;
    logic                 hit_reg;
    logic                 zero_op;
    logic                 ignore_reg;
    logic                 smp_done_reg;
    logic [RATIO_W-1:0]   sample_reg;
    logic [RATIO_W-1:0]   mag_reg;
    logic                 neg_reg;
    logic [WIN_W:0]       wdiv_reg;
    logic                 fresh_reg;
    logic [RATIO_W-1:0]   new_ratio;
    logic [COUNT_W-1:0]   new_count;
    logic [RATIO_W-1:0]   ratio_reg;
    logic [COUNT_W-1:0]   total_reg;
    logic [STAT_W-1:0]    status_reg;
    logic [IDX_W-1:0]     addr;

    logic [KEY_BITS-1:0]  key_rd;
    logic [RATIO_W-1:0]   ratio_rd;
    logic [COUNT_W-1:0]   count_rd;

    logic                 div_start;
    logic [QN_W-1:0]      div_num;
    logic [31:0]          div_den;
    logic                 div_done;
    logic [QN_W-1:0]      div_quo;
    logic                 blend_phase_reg;
    logic [RATIO_W:0]     blended;
    logic [WIN_W-1:0]     n_w;

    // compare valid in the cycle after a read issue
    logic                 rd_pend_reg;
    logic                 stat_hit_now;

    // the one divider serves both the sample division and the blend weight
    assign div_start = ctl.div_start | ctl.blend_start;
    assign div_num   = ctl.blend_start ? QN_W'(mag_reg) : {real_reg, {FRAC_BITS{1'b0}}};
    assign div_den   = ctl.blend_start ? 32'(wdiv_reg) : est_reg;

    krct_div #(.N_W(QN_W), .D_W(32)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign addr = ctl.commit ? IDX_W'(idx_reg) : IDX_W'(idx_reg);

    krct_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_ENTRIES)) u_key_ram (
        .clk (clk), .we (ctl.commit & ~hit_reg), .waddr (addr),
        .wdata (key_reg), .raddr (addr), .rdata (key_rd)
    );
    krct_ram #(.WIDTH(RATIO_W), .DEPTH(TABLE_ENTRIES)) u_ratio_ram (
        .clk (clk), .we (ctl.commit), .waddr (addr),
        .wdata (new_ratio), .raddr (addr), .rdata (ratio_rd)
    );
    krct_ram #(.WIDTH(COUNT_W), .DEPTH(TABLE_ENTRIES)) u_count_ram (
        .clk (clk), .we (ctl.commit), .waddr (addr),
        .wdata (new_count), .raddr (addr), .rdata (count_rd)
    );

    assign zero_op = (real_reg == '0) || (est_reg == '0);

    // blend result: sample if fresh, else ratio +/- quotient, then floor-first clamp; also next count and window
    always_comb
    begin
        if (fresh_reg)
        begin
            blended = {1'b0, sample_reg};
        end
        else if (neg_reg)
        begin
            blended = {1'b0, ratio_rd} - (RATIO_W+1)'(div_quo);
        end
        else
        begin
            blended = {1'b0, ratio_rd} + (RATIO_W+1)'(div_quo);
        end
        if (blended < {1'b0, ratio_floor})
        begin
            new_ratio = ratio_floor;
        end
        else if (blended > {1'b0, ratio_ceiling})
        begin
            new_ratio = ratio_ceiling;
        end
        else
        begin
            new_ratio = blended[RATIO_W-1:0];
        end
        if (!hit_reg)
        begin
            new_count = COUNT_W'(1);
        end
        else if (count_rd == {COUNT_W{1'b1}})
        begin
            new_count = count_rd;
        end
        else
        begin
            new_count = count_rd + 1'b1;
        end
        n_w = (count_rd < COUNT_W'(window_len)) ? count_rd[WIN_W-1:0] : window_len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (ctl.commit && !hit_reg)
        begin
            fill_reg <= fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd;
            key_reg  <= key[KEY_BITS-1:0];
            real_reg <= real_count;
            est_reg  <= est_count;
        end
        // a late done from an abandoned division is dropped by the restart
        if (ctl.div_start)
        begin
            ignore_reg   <= zero_op;
            smp_done_reg <= 1'b0;
        end
        else if (div_done && !blend_phase_reg)
        begin
            // sample must fit in 24 bits when in band since ceiling is 24 bits
            sample_reg   <= div_quo[RATIO_W-1:0];
            smp_done_reg <= 1'b1;
            if (div_quo < QN_W'(ratio_floor) || div_quo > QN_W'(ratio_ceiling))
            begin
                ignore_reg <= 1'b1;
            end
        end
        if (ctl.div_start)
        begin
            blend_phase_reg <= 1'b0;
        end
        else if (ctl.blend_start)
        begin
            blend_phase_reg <= 1'b1;
        end
        if (ctl.scan_clr)
        begin
            idx_reg <= '0;
            hit_reg <= 1'b0;
        end
        else if (ctl.scan_step)
        begin
            // index stays on the matching entry
            if (stat_hit_now)
            begin
                hit_reg <= 1'b1;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
        if (ctl.blend_pre)
        begin
            fresh_reg <= !hit_reg || (count_rd == '0);
            neg_reg   <= sample_reg < ratio_rd;
            mag_reg   <= (sample_reg < ratio_rd) ? ratio_rd - sample_reg
                                                 : sample_reg - ratio_rd;
            wdiv_reg  <= {1'b0, n_w} + 1'b1;
        end
        if (ctl.set_result)
        begin
            if (cmd_reg == CMD_QUERY || ignore_reg)
            begin
                if (hit_reg && count_rd != '0 && ratio_rd != '0)
                begin
                    ratio_reg  <= ratio_rd;
                    total_reg  <= count_rd;
                    status_reg <= (cmd_reg == CMD_QUERY) ? ST_FOUND : ST_IGNORED;
                end
                else
                begin
                    ratio_reg  <= ONE_RATIO;
                    total_reg  <= hit_reg ? count_rd : '0;
                    status_reg <= (cmd_reg == CMD_QUERY) ? ST_DEFAULT : ST_IGNORED;
                end
            end
            else if (!hit_reg && fill_reg >= FILL_W'(TABLE_ENTRIES))
            begin
                ratio_reg  <= ONE_RATIO;
                total_reg  <= '0;
                status_reg <= ST_FULL;
            end
            else
            begin
                ratio_reg  <= new_ratio;
                total_reg  <= new_count;
                status_reg <= ST_UPDATED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= ctl.rd_issue;
        end
    end

    assign stat_hit_now = rd_pend_reg && (key_rd == key_reg);

    assign stat.div_done = div_done;
    assign stat.smp_done = smp_done_reg;
    assign stat.is_query = cmd_reg;
    assign stat.ignore   = ignore_reg;
    assign stat.scan_end = (idx_reg >= fill_reg);
    assign stat.hit      = hit_reg;
    assign stat.full     = (fill_reg >= FILL_W'(TABLE_ENTRIES));

    assign ratio_out    = ratio_reg;
    assign sample_total = total_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

// ----- design/krct_ctrl.sv -----
// ----------------------------------------------------------------------------
// krct_ctrl
// Sequencer: sample division, key scan, blend division, commit, output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module krct_ctrl
    import krct_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    output krct_cmd_t       ctl,
    input  wire krct_stat_t stat
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DIV    = 11'b00000000010,
        S_SCAN   = 11'b00000000100,
        S_WAIT   = 11'b00000001000,
        S_CMP    = 11'b00000010000,
        S_PRE    = 11'b00000100000,
        S_BDIV   = 11'b00001000000,
        S_BWAIT  = 11'b00010000000,
        S_COMMIT = 11'b00100000000,
        S_RES    = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_reg, out_next;

    always_comb
    begin
        state_next = state_reg;
        out_next   = out_reg;
        ctl        = '0;
        if (out_reg && m_ready)
        begin
            out_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                // the result register must be free before a new item starts
                if (s_valid && !out_reg)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                ctl.div_start = 1'b1;
                ctl.scan_clr  = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                // divider runs concurrently with the scan
                if (stat.hit || stat.scan_end)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    ctl.rd_issue = 1'b1;
                    state_next   = S_CMP;
                end
            end
            S_CMP:
            begin
                // compare lands in hit this edge; index advances on a miss
                ctl.scan_step = 1'b1;
                state_next    = S_SCAN;
            end
            S_WAIT:
            begin
                if (stat.smp_done || stat.is_query)
                begin
                    state_next = S_PRE;
                end
                else
                begin
                    state_next = S_BWAIT;
                end
            end
            S_BWAIT:
            begin
                if (stat.smp_done)
                begin
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                if (stat.is_query || stat.ignore || (!stat.hit && stat.full))
                begin
                    ctl.set_result = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    ctl.blend_pre = 1'b1;
                    state_next    = S_BDIV;
                end
            end
            S_BDIV:
            begin
                ctl.blend_start = 1'b1;
                state_next      = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (stat.div_done)
                begin
                    ctl.set_result = 1'b1;
                    ctl.commit     = 1'b1;
                    state_next     = S_RES;
                end
            end
            S_RES:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_reg || m_ready)
                begin
                    out_next   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_reg   <= out_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !out_reg;
    assign m_valid = out_reg;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_valid && !m_ready, m_valid,
        "result dropped under stall")
    `ASSERT_IMPL(a_commit_state, clk, rst_n, ctl.commit, state_reg == S_COMMIT,
        "commit outside commit state")
    `ASSERT_IMPL(a_one_start, clk, rst_n, ctl.div_start, !ctl.blend_start,
        "two divider starts")

endmodule

`default_nettype wire

// ----- design/keyed_ratio_calibration_table.sv -----
// ----------------------------------------------------------------------------
// keyed_ratio_calibration_table
// Per-key ratio estimates with windowed blending, observe and query items.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item: tdata = {est_count, real_count, key}, tuser = cmd
//   (0 observe, 1 query). m_axis returns exactly one result per item:
//   tdata = {status, sample_total, ratio_out}.
//   Items are handled one at a time. The sample divide runs alongside the key
//   scan; an observe that updates then adds the weight divide.
//   The result register holds while m_axis_tready is low, and s_axis_tready
//   stays low until the waiting result is taken, so a stalled receiver
//   stalls the input.
//   Reset empties the table (fill count to zero) and loads register defaults.
//   Config writes (cfg_we/cfg_index/cfg_data) are taken any cycle; write only
//   while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_ratio_calibration_table
    import krct_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = KEY_BITS_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [127:0]         s_axis_tdata,  // key, real_count, est_count
    input  wire logic                 s_axis_tuser,  // cmd
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [63:0]          m_axis_tdata,  // ratio_out, sample_total, status, pad
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [RATIO_W-1:0]   cfg_data
);

    logic [RATIO_W-1:0] floor_reg, ceil_reg;
    logic [WIN_W-1:0]   win_reg;
    krct_cmd_t          ctl;
    krct_stat_t         stat;
    logic [RATIO_W-1:0] ratio_out;
    logic [COUNT_W-1:0] sample_total;
    logic [STAT_W-1:0]  status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= RATIO_W'(16384);
            ceil_reg  <= RATIO_W'(262144);
            win_reg   <= WIN_W'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FLOOR:   floor_reg <= cfg_data;
                CFG_CEILING: ceil_reg  <= cfg_data;
                CFG_WINDOW:  win_reg   <= cfg_data[WIN_W-1:0];
                default:     ;
            endcase
        end
    end

    krct_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .ctl     (ctl),
        .stat    (stat)
    );

    krct_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS),
        .FRAC_BITS     (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .cmd           (s_axis_tuser),
        .key           (s_axis_tdata[63:0]),
        .real_count    (s_axis_tdata[95:64]),
        .est_count     (s_axis_tdata[127:96]),
        .ratio_floor   (floor_reg),
        .ratio_ceiling (ceil_reg),
        .window_len    (win_reg),
        .ratio_out     (ratio_out),
        .sample_total  (sample_total),
        .status        (status)
    );

    assign m_axis_tdata = {5'd0, status, sample_total, ratio_out};

endmodule

`default_nettype wire
